/* rtl/bmm_pkg.sv */
// bmm_pkg: request and response types, decode codes and address map constants
// for the banked memory map decoder
// no dependencies
package bmm_pkg;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        in_boot;
    } req_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [15:0] fwd_address;
        logic [7:0]  fwd_data;
        logic [7:0]  read_data;
    } rsp_t;

    localparam logic [2:0] TGT_INTERNAL = 3'd0;
    localparam logic [2:0] TGT_BOOT     = 3'd1;
    localparam logic [2:0] TGT_CART     = 3'd2;
    localparam logic [2:0] TGT_SOUND    = 3'd3;
    localparam logic [2:0] TGT_IO       = 3'd4;

    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_VIDEO,
        SRC_WORK,
        SRC_HIGH
    } src_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_VIDEO,
        OP_WORK,
        OP_HIGH,
        OP_VBANK,
        OP_WBANK,
        OP_BGSEL,
        OP_BGDATA,
        OP_OBJSEL,
        OP_OBJDATA
    } op_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [15:0] faddr;
        logic [7:0]  fdata;
        src_t        src;
        op_t         op;
    } dec_t;

    localparam logic [15:0] BOOT_LOW_END   = 16'h0100;
    localparam logic [15:0] BOOT_HI_START  = 16'h0200;
    localparam logic [15:0] BOOT_HI_END    = 16'h0900;
    localparam logic [15:0] BOOT_SHIFT     = 16'h0100;
    localparam logic [15:0] VIDEO_START    = 16'h8000;
    localparam logic [15:0] EXT_START      = 16'hA000;
    localparam logic [15:0] WORK_START     = 16'hC000;
    localparam logic [15:0] HIGH_START     = 16'hE000;
    localparam logic [15:0] SOUND_START    = 16'hFF10;
    localparam logic [15:0] SOUND_END      = 16'hFF3F;
    localparam logic [15:0] ADDR_VBANK     = 16'hFF4F;
    localparam logic [15:0] ADDR_WBANK     = 16'hFF70;
    localparam logic [15:0] ADDR_BG_SEL    = 16'hFF68;
    localparam logic [15:0] ADDR_BG_DATA   = 16'hFF69;
    localparam logic [15:0] ADDR_OBJ_SEL   = 16'hFF6A;
    localparam logic [15:0] ADDR_OBJ_DATA  = 16'hFF6B;

    localparam logic [7:0] SEL_MASK     = 8'b1011_1111;
    localparam logic [7:0] SEL_AUTO_INC = 8'h80;

    localparam int HIGH_DEPTH = 8192;
    localparam int HIGH_AW    = 13;

    function automatic logic is_fwd_io(input logic [15:0] a);
        logic hit;
        case (a)
            16'hFF00, 16'hFF04, 16'hFF06, 16'hFF0F,
            16'hFF40, 16'hFF41, 16'hFF44, 16'hFF45, 16'hFF46,
            16'hFF50, 16'hFF51, 16'hFF52, 16'hFF53, 16'hFF54,
            16'hFF55, 16'hFFFF: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

/* rtl/bmm_decode.sv */
// bmm_decode: address map decode of one bus request, with video and work
// store indexes for the current bank selects and mode
// depends on bmm_pkg
module bmm_decode #(
    parameter int VIDEO_BANK_BYTES = 8192,
    parameter int WORK_BANK_BYTES  = 4096
) (
    input  bmm_pkg::req_t                         req,
    input  logic                                  color_mode,
    input  logic                                  video_bank,
    input  logic [2:0]                            work_bank,
    output bmm_pkg::dec_t                         dec,
    output logic [$clog2(2*VIDEO_BANK_BYTES)-1:0] video_idx,
    output logic [$clog2(8*WORK_BANK_BYTES)-1:0]  work_idx
);
    import bmm_pkg::*;

    localparam int VA_W = $clog2(2*VIDEO_BANK_BYTES);
    localparam int WA_W = $clog2(8*WORK_BANK_BYTES);

    // offsets stay below eight times the modulus
    function automatic logic [15:0] wrap_mod(input logic [15:0] x, input logic [15:0] m);
        logic [18:0] step;
        logic [15:0] sub;
        sub = 16'd0;
        for (int k = 1; k < 8; k++)
        begin
            step = 19'(k) * {3'b000, m};
            if ({3'b000, x} >= step)
                sub = step[15:0];
        end
        return x - sub;
    endfunction

    logic [15:0] a;
    logic        wr;
    logic        cart;
    logic        sound;
    logic [15:0] off13;
    logic [15:0] video_full;
    logic [15:0] work_full;
    logic [15:0] vbase;
    logic [15:0] wbase;

    assign a     = req.address;
    assign wr    = (req.action == ACT_WRITE);
    assign cart  = (a < VIDEO_START) || (a >= EXT_START && a < WORK_START);
    assign sound = (a >= SOUND_START) && (a <= SOUND_END);
    assign off13 = {3'b000, a[12:0]};
    assign vbase = video_bank ? 16'(VIDEO_BANK_BYTES) : 16'd0;
    assign wbase = 16'(work_bank) * 16'(WORK_BANK_BYTES);

    always_comb
    begin
        if (color_mode)
            video_full = vbase + wrap_mod(off13, 16'(VIDEO_BANK_BYTES));
        else
            video_full = wrap_mod(off13, 16'(2*VIDEO_BANK_BYTES));

        if (!color_mode)
            work_full = wrap_mod(off13, 16'(8*WORK_BANK_BYTES));
        else if (!a[12])
            work_full = wrap_mod(off13, 16'(WORK_BANK_BYTES));
        else
            work_full = wbase + wrap_mod({4'b0000, a[11:0]}, 16'(WORK_BANK_BYTES));
    end

    assign video_idx = video_full[VA_W-1:0];
    assign work_idx  = work_full[WA_W-1:0];

    always_comb
    begin
        dec.target = TGT_INTERNAL;
        dec.faddr  = a;
        dec.fdata  = wr ? req.write_data : 8'd0;
        dec.src    = SRC_NONE;
        dec.op     = OP_NONE;
        if (!wr)
        begin
            if (req.in_boot && a < BOOT_LOW_END)
                dec.target = TGT_BOOT;
            else if (req.in_boot && a >= BOOT_HI_START && a < BOOT_HI_END)
            begin
                dec.target = TGT_BOOT;
                dec.faddr  = a - BOOT_SHIFT;
            end
            else if (cart)
                dec.target = TGT_CART;
            else if (a < EXT_START)
                dec.src = SRC_VIDEO;
            else if (a < HIGH_START)
                dec.src = SRC_WORK;
            else if (sound)
                dec.target = TGT_SOUND;
            else
                dec.src = SRC_HIGH;
        end
        else
        begin
            if (cart)
                dec.target = TGT_CART;
            else if (a < EXT_START)
                dec.op = OP_VIDEO;
            else if (a < HIGH_START)
                dec.op = OP_WORK;
            else if (sound)
                dec.target = TGT_SOUND;
            else if (is_fwd_io(a))
                dec.target = TGT_IO;
            else if (a == ADDR_VBANK)
                dec.op = OP_VBANK;
            else if (a == ADDR_WBANK)
                dec.op = OP_WBANK;
            else if (a == ADDR_BG_SEL)
                dec.op = OP_BGSEL;
            else if (a == ADDR_BG_DATA)
                dec.op = OP_BGDATA;
            else if (a == ADDR_OBJ_SEL)
                dec.op = OP_OBJSEL;
            else if (a == ADDR_OBJ_DATA)
                dec.op = OP_OBJDATA;
            else
                dec.op = OP_HIGH;
        end
    end

endmodule

/* rtl/banked_memory_map_decoder.sv */
// banked_memory_map_decoder: top level with the video, work and high stores,
// bank and palette select registers and the request sequencer
// depends on bmm_pkg and bmm_decode
//
// One byte bus request in, one response out. After reset the block sweeps
// all three stores to zero, one entry per cycle per store in parallel, until
// the deepest store is swept; in_ready stays low during the sweep while
// color_mode writes are taken. Each request then passes through capture, a
// single access to the store (registered read, or write), and response load.
// Carts, boot ROM, sound and forwarded I/O only get their target code,
// address and write data; video, work and high area accesses are served
// here. A new request is taken while the previous response still waits on
// out_ready.
module banked_memory_map_decoder #(
    parameter int VIDEO_BANK_BYTES = 8192,
    parameter int WORK_BANK_BYTES  = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic          cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  bmm_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bmm_pkg::rsp_t out_data
);
    import bmm_pkg::*;

    localparam int VIDEO_DEPTH = 2*VIDEO_BANK_BYTES;
    localparam int WORK_DEPTH  = 8*WORK_BANK_BYTES;
    localparam int VA_W        = $clog2(VIDEO_DEPTH);
    localparam int WA_W        = $clog2(WORK_DEPTH);
    localparam int CLR_DEPTH0  = (VIDEO_DEPTH > WORK_DEPTH) ? VIDEO_DEPTH : WORK_DEPTH;
    localparam int CLR_DEPTH   = (CLR_DEPTH0 > HIGH_DEPTH) ? CLR_DEPTH0 : HIGH_DEPTH;
    localparam int CLR_W       = $clog2(CLR_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;
    req_t              req_reg;
    logic [2:0]        tgt_reg;
    logic [15:0]       faddr_reg;
    logic [7:0]        fdata_reg;
    src_t              src_reg;
    logic              out_valid_reg;
    rsp_t              out_data_reg;
    logic              color_mode_reg;
    logic              video_bank_reg;
    logic [2:0]        work_bank_reg;
    logic [7:0]        bg_sel_reg;
    logic [7:0]        obj_sel_reg;

    logic [7:0]        video_mem [VIDEO_DEPTH];
    logic [7:0]        work_mem  [WORK_DEPTH];
    logic [7:0]        high_mem  [HIGH_DEPTH];
    logic [7:0]        video_q_reg;
    logic [7:0]        work_q_reg;
    logic [7:0]        high_q_reg;

    dec_t              dec;
    logic [VA_W-1:0]   video_idx;
    logic [WA_W-1:0]   work_idx;

    logic              clearing;
    logic              access;
    logic [2:0]        work_bank_next;
    logic [7:0]        bg_sel_next;
    logic [7:0]        obj_sel_next;

    logic              video_we;
    logic              video_re;
    logic [VA_W-1:0]   video_addr;
    logic [7:0]        video_wdata;
    logic              work_we;
    logic              work_re;
    logic [WA_W-1:0]   work_addr;
    logic [7:0]        work_wdata;
    logic              high_we;
    logic              high_re;
    logic [HIGH_AW-1:0] high_addr;
    logic [7:0]        high_wdata;
    logic [7:0]        rdata;
    logic              out_free;
    logic              out_load;

    bmm_decode #(
        .VIDEO_BANK_BYTES (VIDEO_BANK_BYTES),
        .WORK_BANK_BYTES  (WORK_BANK_BYTES)
    ) u_decode (
        .req        (req_reg),
        .color_mode (color_mode_reg),
        .video_bank (video_bank_reg),
        .work_bank  (work_bank_reg),
        .dec        (dec),
        .video_idx  (video_idx),
        .work_idx   (work_idx)
    );

    assign clearing = (state_reg == ST_CLEAR);
    assign access   = (state_reg == ST_ACCESS);
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == ST_FINISH) && out_free;

    // bank zero selects bank one
    assign work_bank_next = (req_reg.write_data[2:0] == 3'd0) ? 3'd1
                                                              : req_reg.write_data[2:0];
    assign bg_sel_next  = bg_sel_reg[7] ? (SEL_AUTO_INC | {2'b00, bg_sel_reg[5:0] + 6'd1})
                                        : bg_sel_reg;
    assign obj_sel_next = obj_sel_reg[7] ? (SEL_AUTO_INC | {2'b00, obj_sel_reg[5:0] + 6'd1})
                                         : obj_sel_reg;

    always_comb
    begin
        high_wdata = req_reg.write_data;
        high_addr  = req_reg.address[HIGH_AW-1:0];
        high_we    = 1'b0;
        case (dec.op)
            OP_HIGH:
            begin
                high_we = 1'b1;
            end
            OP_VBANK:
            begin
                high_we    = 1'b1;
                high_wdata = {7'd0, req_reg.write_data[0]};
            end
            OP_WBANK:
            begin
                high_we    = 1'b1;
                high_wdata = {5'd0, work_bank_next};
            end
            OP_BGSEL, OP_OBJSEL:
            begin
                high_we    = 1'b1;
                high_wdata = req_reg.write_data & SEL_MASK;
            end
            OP_BGDATA:
            begin
                high_we    = 1'b1;
                high_addr  = ADDR_BG_SEL[HIGH_AW-1:0];
                high_wdata = bg_sel_next;
            end
            OP_OBJDATA:
            begin
                high_we    = 1'b1;
                high_addr  = ADDR_OBJ_SEL[HIGH_AW-1:0];
                high_wdata = obj_sel_next;
            end
            default:
            begin
                high_we = 1'b0;
            end
        endcase
    end

    // clear sweep shares the single port of each store
    always_comb
    begin
        video_we    = access && (dec.op == OP_VIDEO);
        video_re    = access && (dec.src == SRC_VIDEO);
        video_addr  = video_idx;
        video_wdata = req_reg.write_data;
        work_we     = access && (dec.op == OP_WORK);
        work_re     = access && (dec.src == SRC_WORK);
        work_addr   = work_idx;
        work_wdata  = req_reg.write_data;
        high_re     = access && (dec.src == SRC_HIGH);
        if (clearing)
        begin
            video_we    = (clr_cnt_reg < CLR_W'(VIDEO_DEPTH));
            video_addr  = clr_cnt_reg[VA_W-1:0];
            video_wdata = 8'd0;
            work_we     = (clr_cnt_reg < CLR_W'(WORK_DEPTH));
            work_addr   = clr_cnt_reg[WA_W-1:0];
            work_wdata  = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (video_we)
            video_mem[video_addr] <= video_wdata;
        if (video_re)
            video_q_reg <= video_mem[video_addr];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[work_addr] <= work_wdata;
        if (work_re)
            work_q_reg <= work_mem[work_addr];
    end

    always_ff @(posedge clk)
    begin
        if (clearing && clr_cnt_reg < CLR_W'(HIGH_DEPTH))
            high_mem[clr_cnt_reg[HIGH_AW-1:0]] <= 8'd0;
        else if (access && high_we)
            high_mem[high_addr] <= high_wdata;
        if (high_re)
            high_q_reg <= high_mem[high_addr];
    end

    always_comb
    begin
        case (src_reg)
            SRC_VIDEO: rdata = video_q_reg;
            SRC_WORK:  rdata = work_q_reg;
            SRC_HIGH:  rdata = high_q_reg;
            default:   rdata = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            req_reg        <= '0;
            tgt_reg        <= TGT_INTERNAL;
            faddr_reg      <= '0;
            fdata_reg      <= '0;
            src_reg        <= SRC_NONE;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            color_mode_reg <= 1'b0;
            video_bank_reg <= 1'b0;
            work_bank_reg  <= 3'd1;
            bg_sel_reg     <= '0;
            obj_sel_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
                color_mode_reg <= cfg_data;
            if (out_valid_reg && out_ready && !out_load)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
                    if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= in_data;
                        state_reg <= ST_ACCESS;
                    end
                end
                ST_ACCESS:
                begin
                    tgt_reg   <= dec.target;
                    faddr_reg <= dec.faddr;
                    fdata_reg <= dec.fdata;
                    src_reg   <= dec.src;
                    case (dec.op)
                        OP_VBANK:   video_bank_reg <= req_reg.write_data[0];
                        OP_WBANK:   work_bank_reg  <= work_bank_next;
                        OP_BGSEL:   bg_sel_reg     <= req_reg.write_data & SEL_MASK;
                        OP_BGDATA:  bg_sel_reg     <= bg_sel_next;
                        OP_OBJSEL:  obj_sel_reg    <= req_reg.write_data & SEL_MASK;
                        OP_OBJDATA: obj_sel_reg    <= obj_sel_next;
                        default:    ;
                    endcase
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        out_data_reg.target      <= tgt_reg;
                        out_data_reg.fwd_address <= faddr_reg;
                        out_data_reg.fwd_data    <= fdata_reg;
                        out_data_reg.read_data   <= rdata;
                        out_valid_reg            <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
